### src/knt_pkg.sv
// knt_pkg: shared types, constants and the knight move table for the knight's
// tour counter. No dependencies; imported by all but knt_stream_if and knt_ram.
package knt_pkg;

    localparam int COORD_W    = 4;   // start_row / start_col and board coordinates
    localparam int DIM_W      = 5;   // board dimension after clamping, 1..15
    localparam int NEXT_W     = 4;   // next move to try, 0..8
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [NEXT_W-1:0]  NUM_MOVES = 4'd8;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_COLS = 1'b1;

    // knight moves in search order, row and column offsets
    localparam logic signed [2:0] MOVE_DR [8] =
        '{-3'sd2, -3'sd1, 3'sd1, 3'sd2, 3'sd2, 3'sd1, -3'sd1, -3'sd2};
    localparam logic signed [2:0] MOVE_DC [8] =
        '{3'sd1, 3'sd2, 3'sd2, 3'sd1, -3'sd1, -3'sd2, -3'sd2, -3'sd1};

    typedef struct packed {
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
    } knt_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] tour_count;
        logic               count_saturated;
        logic               start_invalid;
    } knt_out_t;

    // one level of the search path
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [NEXT_W-1:0]  next;
    } knt_level_t;

    typedef struct packed {
        logic               start;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [DIM_W-1:0]   rows;
        logic [DIM_W-1:0]   cols;
    } knt_srch_cmd_t;

    typedef struct packed {
        logic               ready;
        logic               done;
        logic [COUNT_W-1:0] count;
        logic               sat;
    } knt_srch_stat_t;

    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_SEARCH,
        TOP_DELIVER
    } knt_top_state_t;

    typedef enum logic [2:0] {
        SRCH_CLEAR,
        SRCH_IDLE,
        SRCH_TRY,
        SRCH_CHECK,
        SRCH_RELOAD
    } knt_srch_state_t;

endpackage

### src/knt_stream_if.sv
// knt_stream_if: valid/ready channel carrying one item of type data_t.
// No dependencies.
interface knt_stream_if #(parameter type data_t = logic);
    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/knt_ram.sv
// knt_ram: generic memory, one write port and one read port, registered read.
// No dependencies.
module knt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/knt_search.sv
// knt_search: backtracking search sequencer; keeps the visited map and the
// path stack in two knt_ram instances. Depends on knt_pkg and knt_ram.
module knt_search #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  knt_pkg::knt_srch_cmd_t cmd,
    output knt_pkg::knt_srch_stat_t stat
);
    import knt_pkg::*;

    localparam int SQUARES = MAX_ROWS * MAX_COLS;
    localparam int SQ_W    = (SQUARES > 1) ? $clog2(SQUARES) : 1;
    localparam int DEPTH_W = $clog2(SQUARES + 1);
    localparam int LVL_W   = $bits(knt_level_t);

    knt_srch_state_t     state_reg, state_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic [COUNT_W-1:0]  tours_reg, tours_next;
    logic                sat_reg, sat_next;
    logic                pend_reg, pend_next;
    logic                done_reg, done_next;
    logic [SQ_W-1:0]     clr_reg, clr_next;
    knt_level_t          top_reg, top_next;
    logic [COORD_W-1:0]  cand_row_reg, cand_row_next;
    logic [COORD_W-1:0]  cand_col_reg, cand_col_next;
    logic [DEPTH_W-1:0]  total_reg, total_next;
    logic [DIM_W-1:0]    rows_reg, rows_next;
    logic [DIM_W-1:0]    cols_reg, cols_next;

    logic                vis_we, vis_re;
    logic [SQ_W-1:0]     vis_waddr, vis_raddr;
    logic [0:0]          vis_wdata, vis_rdata;
    logic                stk_we, stk_re;
    logic [SQ_W-1:0]     stk_waddr, stk_raddr;
    logic [LVL_W-1:0]    stk_wdata, stk_rdata;

    logic [2:0]          mv;
    logic signed [5:0]   nr, nc;
    logic                in_bounds;
    logic                at_full;
    logic [DEPTH_W-1:0]  depth_m1, depth_m2;
    logic [9:0]          area;

    function automatic logic [SQ_W-1:0] sq_addr(input logic [COORD_W-1:0] r,
                                                input logic [COORD_W-1:0] c);
        logic [8:0] lin;
        lin = 9'(r) * 9'(MAX_COLS) + 9'(c);
        return lin[SQ_W-1:0];
    endfunction

    knt_ram #(.WIDTH(1), .DEPTH(SQUARES)) u_visited (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .re    (vis_re),
        .raddr (vis_raddr),
        .rdata (vis_rdata)
    );

    knt_ram #(.WIDTH(LVL_W), .DEPTH(SQUARES)) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign mv        = top_reg.next[2:0];
    assign nr        = $signed({2'b00, top_reg.row}) + $signed({{3{MOVE_DR[mv][2]}}, MOVE_DR[mv]});
    assign nc        = $signed({2'b00, top_reg.col}) + $signed({{3{MOVE_DC[mv][2]}}, MOVE_DC[mv]});
    assign in_bounds = !nr[5] && (nr[4:0] < rows_reg) && !nc[5] && (nc[4:0] < cols_reg);
    assign at_full   = (depth_reg == total_reg);
    assign depth_m1  = depth_reg - DEPTH_W'(1);
    assign depth_m2  = depth_reg - DEPTH_W'(2);
    assign area      = 10'(cmd.rows) * 10'(cmd.cols);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SRCH_CLEAR;
            depth_reg <= '0;
            tours_reg <= '0;
            sat_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            tours_reg <= tours_next;
            sat_reg   <= sat_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        cand_row_reg <= cand_row_next;
        cand_col_reg <= cand_col_next;
        total_reg    <= total_next;
        rows_reg     <= rows_next;
        cols_reg     <= cols_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        tours_next    = tours_reg;
        sat_next      = sat_reg;
        pend_next     = pend_reg;
        done_next     = 1'b0;
        clr_next      = clr_reg;
        top_next      = top_reg;
        cand_row_next = cand_row_reg;
        cand_col_next = cand_col_reg;
        total_next    = total_reg;
        rows_next     = rows_reg;
        cols_next     = cols_reg;
        vis_we        = 1'b0;
        vis_waddr     = '0;
        vis_wdata     = 1'b0;
        vis_re        = 1'b0;
        vis_raddr     = '0;
        stk_we        = 1'b0;
        stk_waddr     = '0;
        stk_wdata     = top_reg;
        stk_re        = 1'b0;
        stk_raddr     = '0;

        case (state_reg)
            SRCH_CLEAR:
            begin
                vis_we    = 1'b1;
                vis_waddr = clr_reg;
                vis_wdata = 1'b0;
                if (clr_reg == SQ_W'(SQUARES - 1))
                begin
                    state_next = SRCH_IDLE;
                    clr_next   = '0;
                    if (pend_reg)
                    begin
                        done_next = 1'b1;
                        pend_next = 1'b0;
                    end
                end
                else
                begin
                    clr_next = clr_reg + SQ_W'(1);
                end
            end

            SRCH_IDLE:
            begin
                if (cmd.start)
                begin
                    top_next   = '{row: cmd.row, col: cmd.col, next: '0};
                    depth_next = DEPTH_W'(1);
                    tours_next = '0;
                    sat_next   = 1'b0;
                    rows_next  = cmd.rows;
                    cols_next  = cmd.cols;
                    total_next = area[DEPTH_W-1:0];
                    vis_we     = 1'b1;
                    vis_waddr  = sq_addr(cmd.row, cmd.col);
                    vis_wdata  = 1'b1;
                    state_next = SRCH_TRY;
                end
            end

            SRCH_TRY:
            begin
                if (at_full || top_reg.next == NUM_MOVES)
                begin
                    if (at_full && tours_reg == COUNT_MAX - COUNT_W'(1))
                    begin
                        // count pinned: abandon the search and wipe the map
                        tours_next = COUNT_MAX;
                        sat_next   = 1'b1;
                        pend_next  = 1'b1;
                        depth_next = '0;
                        clr_next   = '0;
                        state_next = SRCH_CLEAR;
                    end
                    else
                    begin
                        if (at_full)
                        begin
                            tours_next = tours_reg + COUNT_W'(1);
                        end
                        // backtrack: free this square, pop one level
                        vis_we     = 1'b1;
                        vis_waddr  = sq_addr(top_reg.row, top_reg.col);
                        vis_wdata  = 1'b0;
                        depth_next = depth_m1;
                        if (depth_reg == DEPTH_W'(1))
                        begin
                            done_next  = 1'b1;
                            state_next = SRCH_IDLE;
                        end
                        else
                        begin
                            stk_re     = 1'b1;
                            stk_raddr  = depth_m2[SQ_W-1:0];
                            state_next = SRCH_RELOAD;
                        end
                    end
                end
                else
                begin
                    top_next.next = top_reg.next + NEXT_W'(1);
                    if (in_bounds)
                    begin
                        cand_row_next = nr[COORD_W-1:0];
                        cand_col_next = nc[COORD_W-1:0];
                        vis_re        = 1'b1;
                        vis_raddr     = sq_addr(nr[COORD_W-1:0], nc[COORD_W-1:0]);
                        state_next    = SRCH_CHECK;
                    end
                end
            end

            SRCH_CHECK:
            begin
                if (!vis_rdata[0])
                begin
                    vis_we     = 1'b1;
                    vis_waddr  = sq_addr(cand_row_reg, cand_col_reg);
                    vis_wdata  = 1'b1;
                    stk_we     = 1'b1;
                    stk_waddr  = depth_m1[SQ_W-1:0];
                    stk_wdata  = top_reg;
                    top_next   = '{row: cand_row_reg, col: cand_col_reg, next: '0};
                    depth_next = depth_reg + DEPTH_W'(1);
                end
                state_next = SRCH_TRY;
            end

            SRCH_RELOAD:
            begin
                top_next   = stk_rdata;
                state_next = SRCH_TRY;
            end

            default:
            begin
                state_next = SRCH_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    assign stat = '{ready: (state_reg == SRCH_IDLE), done: done_reg,
                    count: tours_reg, sat: sat_reg};

endmodule

### src/knight_tour_counter_core.sv
// knight_tour_counter_core: top level; configuration registers, start check,
// result register and handshakes. Depends on knt_pkg, knt_stream_if, knt_search.
//
//   port      dir  carries
//   in_item   in   start_row, start_col (valid/ready)
//   out_item  out  tour_count, count_saturated, start_invalid (valid/ready)
//   cfg_*     in   board_rows (index 0), board_cols (index 1), write only
//
// an item steps through each knight move tried, a visited-map read for each move that
// lands on the board and a stack read for each backtrack (registered memory reads), then a hand-over
// an off-board start is answered without a search
// reset and a saturated search each run a clearing pass over all MAX_ROWS*MAX_COLS
// squares of the visited map; no item is taken during it
// a finished result waits in the output register while the next item is taken
module knight_tour_counter_core #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    knt_stream_if.sink                        in_item,
    knt_stream_if.source                      out_item,
    input  logic                              cfg_we,
    input  logic [knt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [knt_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import knt_pkg::*;

    knt_top_state_t          state_reg, state_next;
    logic [CFG_DATA_W-1:0]   rows_cfg_reg, rows_cfg_next;
    logic [CFG_DATA_W-1:0]   cols_cfg_reg, cols_cfg_next;
    knt_out_t                pend_reg, pend_next;
    knt_out_t                out_data_reg, out_data_next;
    logic                    out_valid_reg, out_valid_next;

    logic [DIM_W-1:0]        rows_eff, cols_eff;
    logic                    in_fire;
    logic                    start_bad;
    knt_srch_cmd_t           srch_cmd;
    knt_srch_stat_t          srch_stat;

    knt_search #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (srch_cmd),
        .stat  (srch_stat)
    );

    // board size clamped to 1..MAX
    always_comb
    begin
        if (rows_cfg_reg == '0)
            rows_eff = DIM_W'(1);
        else if ({1'b0, rows_cfg_reg} > DIM_W'(MAX_ROWS))
            rows_eff = DIM_W'(MAX_ROWS);
        else
            rows_eff = {1'b0, rows_cfg_reg};

        if (cols_cfg_reg == '0)
            cols_eff = DIM_W'(1);
        else if ({1'b0, cols_cfg_reg} > DIM_W'(MAX_COLS))
            cols_eff = DIM_W'(MAX_COLS);
        else
            cols_eff = {1'b0, cols_cfg_reg};
    end

    assign in_item.ready = (state_reg == TOP_IDLE) && srch_stat.ready;
    assign in_fire       = in_item.valid && in_item.ready;
    assign start_bad     = (in_item.data.start_row == '0) ||
                           ({1'b0, in_item.data.start_row} > rows_eff) ||
                           (in_item.data.start_col == '0) ||
                           ({1'b0, in_item.data.start_col} > cols_eff);

    assign out_item.valid = out_valid_reg;
    assign out_item.data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TOP_IDLE;
            rows_cfg_reg  <= CFG_DATA_W'(8);
            cols_cfg_reg  <= CFG_DATA_W'(8);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_cfg_reg  <= rows_cfg_next;
            cols_cfg_reg  <= cols_cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        rows_cfg_next = rows_cfg_reg;
        cols_cfg_next = cols_cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BOARD_ROWS: rows_cfg_next = cfg_data;
                CFG_BOARD_COLS: cols_cfg_next = cfg_data;
                default:        rows_cfg_next = rows_cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pend_next      = pend_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        srch_cmd       = '{start: 1'b0,
                           row: in_item.data.start_row - COORD_W'(1),
                           col: in_item.data.start_col - COORD_W'(1),
                           rows: rows_eff, cols: cols_eff};

        if (out_valid_reg && out_item.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            TOP_IDLE:
            begin
                if (in_fire)
                begin
                    if (start_bad)
                    begin
                        pend_next  = '{tour_count: '0, count_saturated: 1'b0,
                                      start_invalid: 1'b1};
                        state_next = TOP_DELIVER;
                    end
                    else
                    begin
                        srch_cmd.start = 1'b1;
                        state_next     = TOP_SEARCH;
                    end
                end
            end

            TOP_SEARCH:
            begin
                if (srch_stat.done)
                begin
                    pend_next  = '{tour_count: srch_stat.count,
                                  count_saturated: srch_stat.sat,
                                  start_invalid: 1'b0};
                    state_next = TOP_DELIVER;
                end
            end

            TOP_DELIVER:
            begin
                if (!out_valid_reg || out_item.ready)
                begin
                    out_data_next  = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = TOP_IDLE;
                end
            end

            default:
            begin
                state_next = TOP_IDLE;
            end
        endcase
    end

endmodule

### src/knt_checker.sv
// knt_checker: port-level assertions for knight_tour_counter_core, with the
// bind that attaches them. Depends on knt_pkg.
module knt_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [knt_pkg::COUNT_W-1:0]  tour_count,
    input logic                         count_saturated,
    input logic                         start_invalid
);
    import knt_pkg::*;

    logic       in_acc, out_acc;
    logic [1:0] open_reg, open_next;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        open_next = open_reg;
        if (in_acc && !out_acc)
            open_next = open_reg + 2'd1;
        else if (!in_acc && out_acc)
            open_next = open_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= 2'd0;
        else
            open_reg <= open_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid &&
            $stable(tour_count) && $stable(count_saturated) && $stable(start_invalid))
        else $error("result item changed while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_invalid |-> tour_count == '0 && !count_saturated)
        else $error("off-board start reported a count");

    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && count_saturated |-> tour_count == COUNT_MAX && !start_invalid)
        else $error("saturated flag without full count");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> open_reg != 2'd0)
        else $error("result item with no item outstanding");

    a_two_max: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> open_reg != 2'd2)
        else $error("more than two items outstanding");

endmodule

bind knight_tour_counter_core knt_checker u_knt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_item.valid),
    .in_ready        (in_item.ready),
    .out_valid       (out_item.valid),
    .out_ready       (out_item.ready),
    .tour_count      (out_item.data.tour_count),
    .count_saturated (out_item.data.count_saturated),
    .start_invalid   (out_item.data.start_invalid)
);

### sim/knt_tour_checker.sv
`timescale 1ns / 1ps
// knt_tour_checker: watches the start, result and register ports of
// knight_tour_counter_core, predicts each tour count and compares it.
// Depends on knt_pkg.
module knt_tour_checker #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  knt_pkg::knt_in_t               in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  knt_pkg::knt_out_t              out_data,
    input  logic                           cfg_we,
    input  logic [knt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [knt_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             open_results,
    output int                             error_count
);
    import knt_pkg::*;

    logic [CFG_DATA_W-1:0] rows_setting = 4'd8;
    logic [CFG_DATA_W-1:0] cols_setting = 4'd8;
    knt_out_t              expected_counts_q [$];
    int                    mismatches = 0;

    // depth-first enumeration of every tour from the start square
    function automatic knt_out_t count_tours(input knt_in_t item);
        int          rows;
        int          cols;
        int          squares;
        int          depth;
        int          lvl;
        int          m;
        int          dr;
        int          dc;
        int          nr;
        int          nc;
        int          path_row [MAX_ROWS*MAX_COLS];
        int          path_col [MAX_ROWS*MAX_COLS];
        int          path_next [MAX_ROWS*MAX_COLS];
        bit          occupied [MAX_ROWS][MAX_COLS];
        logic [31:0] found;
        knt_out_t    res;

        res = '0;
        rows = (rows_setting == 0) ? 1
             : ((rows_setting > MAX_ROWS) ? MAX_ROWS : int'(rows_setting));
        cols = (cols_setting == 0) ? 1
             : ((cols_setting > MAX_COLS) ? MAX_COLS : int'(cols_setting));
        squares = rows * cols;
        if (item.start_row < 1 || item.start_row > rows ||
            item.start_col < 1 || item.start_col > cols)
        begin
            res.start_invalid = 1'b1;
            return res;
        end

        for (int i = 0; i < MAX_ROWS; i++)
            for (int j = 0; j < MAX_COLS; j++)
                occupied[i][j] = 1'b0;
        found = '0;
        path_row[0] = item.start_row - 1;
        path_col[0] = item.start_col - 1;
        path_next[0] = 0;
        occupied[path_row[0]][path_col[0]] = 1'b1;
        depth = 1;

        while (depth > 0)
        begin
            lvl = depth - 1;
            if (depth == squares || path_next[lvl] >= 8)
            begin
                if (depth == squares)
                begin
                    found++;
                    if (found == COUNT_MAX)
                    begin
                        res.count_saturated = 1'b1;
                        break;
                    end
                end
                occupied[path_row[lvl]][path_col[lvl]] = 1'b0;
                depth--;
            end
            else
            begin
                m = path_next[lvl];
                path_next[lvl]++;
                case (m)
                    0: begin dr = -2; dc =  1; end
                    1: begin dr = -1; dc =  2; end
                    2: begin dr =  1; dc =  2; end
                    3: begin dr =  2; dc =  1; end
                    4: begin dr =  2; dc = -1; end
                    5: begin dr =  1; dc = -2; end
                    6: begin dr = -1; dc = -2; end
                    default: begin dr = -2; dc = -1; end
                endcase
                nr = path_row[lvl] + dr;
                nc = path_col[lvl] + dc;
                if (nr >= 0 && nr < rows && nc >= 0 && nc < cols)
                begin
                    if (!occupied[nr][nc])
                    begin
                        occupied[nr][nc] = 1'b1;
                        path_row[depth] = nr;
                        path_col[depth] = nc;
                        path_next[depth] = 0;
                        depth++;
                    end
                end
            end
        end

        res.tour_count = found;
        return res;
    endfunction

    always @(posedge clk)
    begin
        knt_out_t want;

        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BOARD_ROWS)
                    rows_setting = cfg_data;
                else if (cfg_index == CFG_BOARD_COLS)
                    cols_setting = cfg_data;
            end

            // results first: an item taken at this edge cannot be answered yet
            if (out_valid && out_ready)
            begin
                if (expected_counts_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result: count %0d sat %0b invalid %0b",
                                 $realtime, out_data.tour_count,
                                 out_data.count_saturated, out_data.start_invalid);
                end
                else
                begin
                    want = expected_counts_q.pop_front();
                    if (out_data.tour_count !== want.tour_count ||
                        out_data.count_saturated !== want.count_saturated ||
                        out_data.start_invalid !== want.start_invalid)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result mismatch: expected count %0d sat %0b invalid %0b",
                                     $realtime, want.tour_count, want.count_saturated,
                                     want.start_invalid);
                            $display("%0t: result mismatch: got count %0d sat %0b invalid %0b",
                                     $realtime, out_data.tour_count,
                                     out_data.count_saturated, out_data.start_invalid);
                        end
                    end
                end
            end

            if (in_valid && in_ready)
                expected_counts_q.push_back(count_tours(in_data));

            open_results <= expected_counts_q.size();
            error_count <= mismatches;
        end
    end

endmodule

### sim/knight_tour_counter_core_test.sv
`timescale 1ns / 1ps
// knight_tour_counter_core_test: clock, reset, board settings and start items
// for knight_tour_counter_core, with knt_tour_checker beside it for the counts.
// Depends on knt_pkg, knt_stream_if, knt_tour_checker and the block itself.
module knight_tour_counter_core_test;
    import knt_pkg::*;

    localparam int MAX_ROWS    = 8;
    localparam int MAX_COLS    = 8;
    localparam int HOLD_CYCLES = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    open_results;
    int                    error_count;
    int                    holds_asked;
    int                    holds_done;

    knt_stream_if #(.data_t(knt_in_t))  in_item ();
    knt_stream_if #(.data_t(knt_out_t)) out_item ();

    knight_tour_counter_core #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    knt_tour_checker #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_item.valid),
        .in_ready     (in_item.ready),
        .in_data      (in_item.data),
        .out_valid    (out_item.valid),
        .out_ready    (out_item.ready),
        .out_data     (out_item.data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .open_results (open_results),
        .error_count  (error_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #400_000_000;
        $display("** knight_tour_counter_core: FAILED **");
        $finish;
    end

    // offer one start square and return at the edge that takes it
    task automatic offer_start(input logic [COORD_W-1:0] r, input logic [COORD_W-1:0] c);
        in_item.data <= knt_in_t'{start_row: r, start_col: c};
        in_item.valid <= 1'b1;
        @(posedge clk);
        while (!in_item.ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_item.valid <= 1'b0;
        @(posedge clk);
        while (open_results != 0)
            @(posedge clk);
    endtask

    task automatic set_board(input logic [CFG_DATA_W-1:0] rows_code,
                             input logic [CFG_DATA_W-1:0] cols_code);
        cfg_we <= 1'b1;
        cfg_index <= CFG_BOARD_ROWS;
        cfg_data <= rows_code;
        @(posedge clk);
        cfg_index <= CFG_BOARD_COLS;
        cfg_data <= cols_code;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random stall modes, plus long hold-offs on request
    initial
    begin
        int tick;
        int mode;

        tick = 0;
        mode = 0;
        out_item.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                out_item.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else
            begin
                tick++;
                if (tick % 50 == 0)
                    mode = $urandom_range(0, 3);
                case (mode)
                    0: out_item.ready <= 1'b1;
                    1: out_item.ready <= ($urandom_range(0, 1) == 1);
                    2: out_item.ready <= ($urandom_range(0, 3) == 0);
                    default: out_item.ready <= (tick % 3 != 0);
                endcase
            end
        end
    end

    initial
    begin
        int                 phase;
        int                 k;
        int                 rows;
        int                 cols;
        int                 n_items;
        int                 burst_left;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
        logic [CFG_DATA_W-1:0] rows_code;
        logic [CFG_DATA_W-1:0] cols_code;

        rst_n <= 1'b0;
        in_item.valid <= 1'b0;
        in_item.data <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_BOARD_ROWS;
        cfg_data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full 8x8 board after reset: off-board starts only, a search would never end
        offer_start(4'd0, 4'd0);
        offer_start(4'd15, 4'd15);
        offer_start(4'd9, 4'd1);
        offer_start(4'd1, 4'd9);
        wait_idle();

        // single square: one tour
        set_board(4'd1, 4'd1);
        offer_start(4'd1, 4'd1);
        offer_start(4'd2, 4'd1);
        offer_start(4'd1, 4'd2);
        wait_idle();

        // rows of zero and cols of 15 clamp to 1x8
        set_board(4'd0, 4'd15);
        offer_start(4'd1, 4'd1);
        offer_start(4'd1, 4'd8);
        offer_start(4'd1, 4'd9);
        wait_idle();

        set_board(4'd15, 4'd2);
        offer_start(4'd8, 4'd2);
        offer_start(4'd1, 4'd1);
        wait_idle();

        set_board(4'd3, 4'd4);
        offer_start(4'd1, 4'd1);
        offer_start(4'd2, 4'd2);
        offer_start(4'd3, 4'd4);
        offer_start(4'd2, 4'd3);
        wait_idle();

        set_board(4'd4, 4'd4);
        offer_start(4'd1, 4'd1);
        wait_idle();

        // the center of 3x3 has no knight move at all
        set_board(4'd3, 4'd3);
        offer_start(4'd2, 4'd2);
        offer_start(4'd1, 4'd1);
        wait_idle();

        for (phase = 0; phase < 8; phase++)
        begin
            // boards stay small: the search is exhaustive
            case ((phase == 0) ? 9 : $urandom_range(0, 14))
                0:  begin rows = 1; cols = 1; end
                1:  begin rows = 1; cols = 4; end
                2:  begin rows = 1; cols = 8; end
                3:  begin rows = 8; cols = 1; end
                4:  begin rows = 2; cols = 3; end
                5:  begin rows = 2; cols = 8; end
                6:  begin rows = 8; cols = 2; end
                7:  begin rows = 3; cols = 2; end
                8:  begin rows = 3; cols = 3; end
                9:  begin rows = 2; cols = 5; end
                10: begin rows = 5; cols = 2; end
                11: begin rows = 3; cols = 4; end
                12: begin rows = 4; cols = 3; end
                13: begin rows = 3; cols = 1; end
                default: begin rows = 4; cols = 4; end
            endcase
            rows_code = CFG_DATA_W'(rows);
            cols_code = CFG_DATA_W'(cols);
            if (rows == 1 && $urandom_range(0, 1) == 1)
                rows_code = 4'd0;
            if (rows == 8 && $urandom_range(0, 1) == 1)
                rows_code = CFG_DATA_W'($urandom_range(9, 15));
            if (cols == 1 && $urandom_range(0, 1) == 1)
                cols_code = 4'd0;
            if (cols == 8 && $urandom_range(0, 1) == 1)
                cols_code = CFG_DATA_W'($urandom_range(9, 15));
            set_board(rows_code, cols_code);

            n_items = (rows * cols == 16) ? 3 : 12;
            // long stall on results while items keep coming
            if (phase == 0)
                holds_asked++;
            burst_left = $urandom_range(1, 10);
            for (k = 0; k < n_items; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    r = COORD_W'($urandom_range(0, 15));
                    c = COORD_W'($urandom_range(0, 15));
                end
                else
                begin
                    r = COORD_W'($urandom_range(1, rows));
                    c = COORD_W'($urandom_range(1, cols));
                end
                offer_start(r, c);
                burst_left--;
                if (phase == 3 && k == n_items / 2)
                    wait_idle();
                else if (burst_left == 0)
                begin
                    in_item.valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                    burst_left = $urandom_range(1, 10);
                end
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("** knight_tour_counter_core: PASSED **");
        else
            $display("** knight_tour_counter_core: FAILED **");
        $finish;
    end

endmodule
